// File: sv/hdu_pkg.sv
// hdu_pkg: shared types and constants for the half-duplex UART with receive stack.
// Used by half_duplex_uart_with_rx_stack; no dependencies.
`timescale 1ns / 1ps

package hdu_pkg;

  // configuration register indexes
  localparam logic CFG_BIT_PERIOD  = 1'b0;
  localparam logic CFG_HALF_PERIOD = 1'b1;

  localparam logic [15:0] BIT_PERIOD_RST  = 16'd104;
  localparam logic [14:0] HALF_PERIOD_RST = 15'd52;

  localparam int STACK_DEPTH_DEF = 16;

  // shared mode register codes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_RX   = 2'd1;
  localparam logic [1:0] MODE_TX   = 2'd2;

  // bit events per frame: start, eight data, stop
  localparam logic [3:0] FRAME_BITS = 4'd10;

  typedef struct packed {
    logic       pop_request;
    logic [7:0] send_byte;
    logic       send_valid;
    logic       rx_line;
  } tick_t;

  typedef struct packed {
    logic [4:0] stack_count;
    logic [7:0] popped_byte;
    logic       pop_valid;
    logic [7:0] last_rx_byte;
    logic       frame_error;
    logic       rx_done;
    logic       rx_busy;
    logic       tx_busy;
    logic       txd;
  } result_t;

endpackage

// File: sv/hdu_ram.sv
// hdu_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module hdu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/half_duplex_uart_with_rx_stack.sv
// Half-duplex 8N1 UART transceiver, one timer tick per input transfer.
// Results are registered; a skid stage holds one more while the output stalls.
// Throughput: one tick per cycle; input stays ready until the skid stage is full.
// The stack top is prefetched from the stack RAM's registered read port each cycle.
// Reset (rst_n low, synchronous): idle, lines high, stack empty, default bit timing.
// Depends on hdu_pkg and hdu_ram.
`timescale 1ns / 1ps

module half_duplex_uart_with_rx_stack
  import hdu_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [15:0] cfg_wdata,

  input  logic        in_tvalid,
  output logic        in_tready,
  // rx_line, send_valid, send_byte[7:0], pop_request, zero pad
  input  logic [15:0] in_tdata,

  output logic        out_tvalid,
  input  logic        out_tready,
  // txd, tx_busy, rx_busy, rx_done, frame_error, last_rx_byte[7:0],
  // pop_valid, popped_byte[7:0], stack_count[4:0], zero pad
  output logic [31:0] out_tdata
);

  localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_MAX = CNT_W'(STACK_DEPTH);

  // configuration
  logic [15:0] bit_period_r;
  logic [14:0] half_period_r;
  logic [15:0] bit_load;
  logic [15:0] half_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r  <= BIT_PERIOD_RST;
      half_period_r <= HALF_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_BIT_PERIOD:  bit_period_r  <= cfg_wdata;
        CFG_HALF_PERIOD: half_period_r <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // zero periods behave as one
  assign bit_load  = (bit_period_r == 16'd0) ? 16'd1 : bit_period_r;
  assign half_load = (half_period_r == 15'd0) ? 16'd1 : {1'b0, half_period_r};

  // state
  logic [1:0]       mode_r, mode_nxt;
  logic [3:0]       bit_cnt_r, bit_cnt_nxt;
  logic [8:0]       tx_shift_r, tx_shift_nxt;
  logic [10:0]      rx_shift_r, rx_shift_nxt;
  logic [15:0]      tick_r, tick_nxt;
  logic             prev_rx_r;
  logic             line_r, line_nxt;
  logic [CNT_W-1:0] depth_r, depth_nxt;
  logic [7:0]       last_byte_r, last_byte_nxt;
  logic             byp_r;
  logic [7:0]       byp_byte_r;

  tick_t   tk;
  result_t res;
  logic    acc;

  logic             push;
  logic [CNT_W-1:0] depth_pop;
  logic [7:0]       top_byte;
  logic [7:0]       ram_rd;
  logic [15:0]      tick_dec;
  logic             fire;
  logic [10:0]      rx_sh;
  logic             done, ferr, pvalid;
  logic [7:0]       pbyte;
  logic [CNT_W+4:0] cnt_ext;

  assign tk  = tick_t'(in_tdata[10:0]);
  assign acc = in_tvalid && in_tready;

  assign top_byte = byp_r ? byp_byte_r : ram_rd;
  assign tick_dec = (tick_r != 16'd0) ? tick_r - 16'd1 : 16'd0;
  assign fire     = (tick_dec == 16'd0);
  assign rx_sh    = {1'b0, tk.rx_line, rx_shift_r[9:1]};

  always_comb begin
    mode_nxt      = mode_r;
    bit_cnt_nxt   = bit_cnt_r;
    tx_shift_nxt  = tx_shift_r;
    rx_shift_nxt  = rx_shift_r;
    tick_nxt      = tick_r;
    line_nxt      = line_r;
    last_byte_nxt = last_byte_r;
    done          = 1'b0;
    ferr          = 1'b0;
    pvalid        = 1'b0;
    pbyte         = 8'd0;
    push          = 1'b0;
    depth_pop     = depth_r;

    // pop acts first, on the stack as it stood
    if (tk.pop_request && depth_r != '0) begin
      depth_pop = depth_r - 1'b1;
      pbyte     = top_byte;
      pvalid    = 1'b1;
    end

    unique case (mode_r)
      MODE_IDLE: begin
        if (prev_rx_r && !tk.rx_line) begin
          rx_shift_nxt = 11'd0;
          bit_cnt_nxt  = FRAME_BITS;
          tick_nxt     = half_load;
          mode_nxt     = MODE_RX;
        end else if (tk.send_valid) begin
          tx_shift_nxt = {1'b1, tk.send_byte};
          bit_cnt_nxt  = FRAME_BITS;
          tick_nxt     = half_load;
          mode_nxt     = MODE_TX;
        end
      end
      MODE_TX: begin
        tick_nxt = tick_dec;
        if (fire) begin
          if (bit_cnt_r >= FRAME_BITS) begin
            line_nxt    = 1'b0;
            bit_cnt_nxt = FRAME_BITS - 4'd1;
            tick_nxt    = bit_load;
          end else if (bit_cnt_r != 4'd0) begin
            line_nxt     = tx_shift_r[0];
            tx_shift_nxt = {1'b0, tx_shift_r[8:1]};
            bit_cnt_nxt  = bit_cnt_r - 4'd1;
            tick_nxt     = bit_load;
          end else begin
            line_nxt = 1'b1;
            mode_nxt = MODE_IDLE;
          end
        end
      end
      MODE_RX: begin
        tick_nxt = tick_dec;
        if (fire) begin
          rx_shift_nxt = rx_sh;
          bit_cnt_nxt  = bit_cnt_r - 4'd1;
          if (bit_cnt_nxt != 4'd0) begin
            tick_nxt = bit_load;
          end else begin
            done     = 1'b1;
            mode_nxt = MODE_IDLE;
            // start sample low, stop sample high
            if (rx_sh[9] && !rx_sh[0]) begin
              last_byte_nxt = rx_sh[8:1];
              push          = (depth_pop < DEPTH_MAX);
            end else begin
              ferr = 1'b1;
            end
          end
        end
      end
      default: mode_nxt = MODE_IDLE;
    endcase

    depth_nxt = push ? depth_pop + 1'b1 : depth_pop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      bit_cnt_r   <= 4'd0;
      tx_shift_r  <= 9'd0;
      rx_shift_r  <= 11'd0;
      tick_r      <= 16'd0;
      prev_rx_r   <= 1'b1;
      line_r      <= 1'b1;
      depth_r     <= '0;
      last_byte_r <= 8'd0;
      byp_r       <= 1'b0;
      byp_byte_r  <= 8'd0;
    end else if (acc) begin
      mode_r      <= mode_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      tx_shift_r  <= tx_shift_nxt;
      rx_shift_r  <= rx_shift_nxt;
      tick_r      <= tick_nxt;
      prev_rx_r   <= tk.rx_line;
      line_r      <= line_nxt;
      depth_r     <= depth_nxt;
      last_byte_r <= last_byte_nxt;
      // a pushed byte is the new top; RAM read would miss the same-edge write
      byp_r       <= push;
      byp_byte_r  <= last_byte_nxt;
    end
  end

  // stack storage; read port always points at the top after this tick
  logic [CNT_W-1:0] rd_ptr;
  assign rd_ptr = (acc ? depth_nxt : depth_r) - 1'b1;

  hdu_ram #(
    .WIDTH (8),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (acc && push),
    .wr_addr (ADDR_W'(depth_pop)),
    .wr_data (last_byte_nxt),
    .rd_addr (ADDR_W'(rd_ptr)),
    .rd_data (ram_rd)
  );

  // result for this tick
  assign cnt_ext = {5'd0, depth_nxt};

  always_comb begin
    res.txd          = line_nxt;
    res.tx_busy      = (mode_nxt == MODE_TX);
    res.rx_busy      = (mode_nxt == MODE_RX);
    res.rx_done      = done;
    res.frame_error  = ferr;
    res.last_rx_byte = last_byte_nxt;
    res.pop_valid    = pvalid;
    res.popped_byte  = pbyte;
    res.stack_count  = cnt_ext[4:0];
  end

  // output register plus skid stage
  logic    out_valid_r, skid_valid_r;
  result_t out_r, skid_r;
  logic    take;

  assign take      = out_valid_r && out_tready;
  // no transfer is taken while reset is held
  assign in_tready = rst_n && !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= acc;
      end
    end else if (acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || take) begin
      out_r <= skid_valid_r ? skid_r : res;
    end
    if (acc && out_valid_r && !take) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_r};

endmodule

// File: tb/tb.sv
// tb: self-checking bench for half_duplex_uart_with_rx_stack, one timer tick per transfer.
// Directed rows, then randomized 8N1 frame traffic over several timing settings.
// Depends on hdu_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;
  import hdu_pkg::*;

  localparam int LIFO_DEPTH = STACK_DEPTH_DEF;

  typedef struct packed {
    logic        is_write;
    logic        reg_sel;
    logic [15:0] reg_val;
    tick_t       tick;
    logic        typed;
    result_t     want;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_idx;
  logic [15:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;

  half_duplex_uart_with_rx_stack u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // UART predictor state
  logic [1:0]  uart_mode;
  logic [3:0]  bit_events_left;
  logic [8:0]  tx_frame;
  logic [10:0] rx_frame;
  logic [15:0] tick_countdown;
  logic        rx_prev;
  logic        tx_level;
  logic [7:0]  rx_lifo [LIFO_DEPTH];
  logic [4:0]  lifo_fill;
  logic [7:0]  newest_byte;
  logic [15:0] bit_ticks;
  logic [14:0] half_ticks;

  result_t    results_due[$];
  dir_row_t   directed_rows[$];
  result_t    seen;
  result_t    due;
  bit         no_gaps;
  int         mismatches;
  int         results_checked;
  int         ticks_sent;
  int         n_good, n_bad, n_drops, n_pops, n_sends, n_cfg_writes;

  function automatic logic [15:0] ticks_or_one(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  task automatic advance_uart(input tick_t t, output result_t r);
    r = '0;
    // pop sees the stack as it stood before any push this tick
    if (t.pop_request && lifo_fill != 5'd0) begin
      lifo_fill = lifo_fill - 5'd1;
      r.popped_byte = rx_lifo[lifo_fill];
      r.pop_valid = 1'b1;
      n_pops++;
    end
    case (uart_mode)
      MODE_IDLE: begin
        if (rx_prev && !t.rx_line) begin
          rx_frame = '0;
          bit_events_left = FRAME_BITS;
          tick_countdown = ticks_or_one({1'b0, half_ticks});
          uart_mode = MODE_RX;
        end else if (t.send_valid) begin
          tx_frame = {1'b1, t.send_byte};
          bit_events_left = FRAME_BITS;
          tick_countdown = ticks_or_one({1'b0, half_ticks});
          uart_mode = MODE_TX;
          n_sends++;
        end
      end
      MODE_TX: begin
        if (tick_countdown != 16'd0) tick_countdown--;
        if (tick_countdown == 16'd0) begin
          if (bit_events_left >= FRAME_BITS) begin
            tx_level = 1'b0;
            bit_events_left = FRAME_BITS - 4'd1;
            tick_countdown = ticks_or_one(bit_ticks);
          end else if (bit_events_left != 4'd0) begin
            tx_level = tx_frame[0];
            tx_frame = tx_frame >> 1;
            bit_events_left--;
            tick_countdown = ticks_or_one(bit_ticks);
          end else begin
            tx_level = 1'b1;
            uart_mode = MODE_IDLE;
          end
        end
      end
      MODE_RX: begin
        if (tick_countdown != 16'd0) tick_countdown--;
        if (tick_countdown == 16'd0) begin
          rx_frame = {1'b0, rx_frame[10] | t.rx_line, rx_frame[9:1]};
          bit_events_left = bit_events_left - 4'd1;
          if (bit_events_left != 4'd0) begin
            tick_countdown = ticks_or_one(bit_ticks);
          end else begin
            r.rx_done = 1'b1;
            if (rx_frame[9] && !rx_frame[0]) begin
              newest_byte = rx_frame[8:1];
              n_good++;
              if (lifo_fill < LIFO_DEPTH) begin
                rx_lifo[lifo_fill] = newest_byte;
                lifo_fill++;
              end else begin
                n_drops++;
              end
            end else begin
              r.frame_error = 1'b1;
              n_bad++;
            end
            uart_mode = MODE_IDLE;
          end
        end
      end
      default: uart_mode = MODE_IDLE;
    endcase
    rx_prev = t.rx_line;
    r.txd = tx_level;
    r.tx_busy = (uart_mode == MODE_TX);
    r.rx_busy = (uart_mode == MODE_RX);
    r.last_rx_byte = newest_byte;
    r.stack_count = lifo_fill;
  endtask

  function automatic tick_t mk_tick(input logic rx, input logic sv, input logic [7:0] b,
                                    input logic pop);
    tick_t t;
    t.rx_line = rx;
    t.send_valid = sv;
    t.send_byte = b;
    t.pop_request = pop;
    return t;
  endfunction

  function automatic result_t res(input logic txd, input logic txb, input logic rxb,
                                  input logic done, input logic ferr, input logic [7:0] last,
                                  input logic pv, input logic [7:0] pb, input logic [4:0] cnt);
    result_t r;
    r.txd = txd;
    r.tx_busy = txb;
    r.rx_busy = rxb;
    r.rx_done = done;
    r.frame_error = ferr;
    r.last_rx_byte = last;
    r.pop_valid = pv;
    r.popped_byte = pb;
    r.stack_count = cnt;
    return r;
  endfunction

  function automatic dir_row_t row_tick(input tick_t t);
    dir_row_t r;
    r = '0;
    r.tick = t;
    return r;
  endfunction

  function automatic dir_row_t row_checked(input tick_t t, input result_t want);
    dir_row_t r;
    r = '0;
    r.tick = t;
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic dir_row_t row_write(input logic sel, input logic [15:0] val);
    dir_row_t r;
    r = '0;
    r.is_write = 1'b1;
    r.reg_sel = sel;
    r.reg_val = val;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch on result %0d: %s got 0x%0h, want 0x%0h",
               results_checked, what, got, want);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen = out_tdata[26:0];
      if (results_due.size() == 0) begin
        report_mismatch("result with nothing due", seen, 0);
      end else begin
        due = results_due.pop_front();
        if (seen.txd !== due.txd) report_mismatch("txd", seen.txd, due.txd);
        if (seen.tx_busy !== due.tx_busy) report_mismatch("tx_busy", seen.tx_busy, due.tx_busy);
        if (seen.rx_busy !== due.rx_busy) report_mismatch("rx_busy", seen.rx_busy, due.rx_busy);
        if (seen.rx_done !== due.rx_done) report_mismatch("rx_done", seen.rx_done, due.rx_done);
        if (seen.frame_error !== due.frame_error)
          report_mismatch("frame_error", seen.frame_error, due.frame_error);
        if (seen.last_rx_byte !== due.last_rx_byte)
          report_mismatch("last_rx_byte", seen.last_rx_byte, due.last_rx_byte);
        if (seen.pop_valid !== due.pop_valid)
          report_mismatch("pop_valid", seen.pop_valid, due.pop_valid);
        if (seen.popped_byte !== due.popped_byte)
          report_mismatch("popped_byte", seen.popped_byte, due.popped_byte);
        if (seen.stack_count !== due.stack_count)
          report_mismatch("stack_count", seen.stack_count, due.stack_count);
      end
      results_checked++;
    end
  end

  // result side backpressure
  initial begin : result_stalls
    int stall;
    out_tready = 1'b0;
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  task automatic drive_tick(input tick_t t, input logic typed, input result_t want);
    result_t predicted;
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, t};
    do @(posedge clk); while (!in_tready);
    advance_uart(t, predicted);
    results_due.push_back(typed ? want : predicted);
    ticks_sent++;
  endtask

  task automatic rand_tick(input logic rx, input int pop_pct, input int send_pct);
    tick_t t;
    t.rx_line = rx;
    t.send_valid = ($urandom_range(0, 99) < send_pct);
    t.send_byte = 8'($urandom_range(0, 255));
    t.pop_request = ($urandom_range(0, 99) < pop_pct);
    drive_tick(t, 1'b0, '0);
  endtask

  task automatic write_reg(input logic sel, input logic [15:0] val);
    in_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= sel;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (sel == CFG_BIT_PERIOD) bit_ticks = val;
    else half_ticks = val[14:0];
    n_cfg_writes++;
    @(posedge clk);
  endtask

  task automatic run_phase(input logic [15:0] bp, input logic [15:0] hp, input int n_ticks,
                           input int pop_pct, input int noise_pct, input int send_pct,
                           input bit steady_run);
    int stop_at;
    int kind;
    logic [9:0] frame_bits;
    logic lvl;
    bit noisy;
    while (uart_mode != MODE_IDLE) rand_tick(1'b1, 0, 0);
    write_reg(CFG_BIT_PERIOD, bp);
    write_reg(CFG_HALF_PERIOD, hp);
    no_gaps = steady_run;
    stop_at = ticks_sent + n_ticks;
    while (ticks_sent < stop_at) begin
      if (uart_mode != MODE_IDLE) begin
        rand_tick(($urandom_range(0, 99) < noise_pct / 4) ? 1'b0 : 1'b1, pop_pct, 10);
      end else if ($urandom_range(0, 99) < send_pct) begin
        rand_tick(1'b1, pop_pct, 100);
      end else begin
        // start, data LSB first, stop; noise breaks one framing bit or flips ticks
        frame_bits = {1'b1, 8'($urandom_range(0, 255)), 1'b0};
        noisy = 1'b0;
        if ($urandom_range(0, 99) < noise_pct) begin
          kind = $urandom_range(0, 2);
          if (kind == 0) frame_bits[9] = 1'b0;
          else if (kind == 1) frame_bits[0] = 1'b1;
          else noisy = 1'b1;
        end
        for (int k = 0; k < 10; k++) begin
          for (int j = 0; j < bit_ticks; j++) begin
            lvl = frame_bits[k];
            if (noisy && $urandom_range(0, 99) < 10) lvl = ~lvl;
            rand_tick(lvl, pop_pct, 2);
          end
        end
        repeat ($urandom_range(0, 3)) rand_tick(1'b1, pop_pct, 0);
      end
    end
    while (uart_mode != MODE_IDLE) rand_tick(1'b1, pop_pct, 10);
    no_gaps = 1'b0;
  endtask

  initial begin
    logic [9:0] a5_frame;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_BIT_PERIOD;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    no_gaps = 1'b0;
    mismatches = 0;
    results_checked = 0;
    ticks_sent = 0;
    n_good = 0;
    n_bad = 0;
    n_drops = 0;
    n_pops = 0;
    n_sends = 0;
    n_cfg_writes = 0;
    uart_mode = MODE_IDLE;
    bit_events_left = '0;
    tx_frame = '0;
    rx_frame = '0;
    tick_countdown = '0;
    rx_prev = 1'b1;
    tx_level = 1'b1;
    lifo_fill = '0;
    newest_byte = '0;
    bit_ticks = BIT_PERIOD_RST;
    half_ticks = HALF_PERIOD_RST;

    // directed rows: reset state, empty pop, edge beating a send, one clean 0xA5 frame,
    // pop of it, a send, then an edge and a send while transmitting
    a5_frame = {1'b1, 8'hA5, 1'b0};
    directed_rows.push_back(row_checked(mk_tick(1, 0, 8'h00, 0),
                                        res(1, 0, 0, 0, 0, 8'h00, 0, 8'h00, 5'd0)));
    directed_rows.push_back(row_checked(mk_tick(1, 0, 8'h00, 1),
                                        res(1, 0, 0, 0, 0, 8'h00, 0, 8'h00, 5'd0)));
    directed_rows.push_back(row_write(CFG_BIT_PERIOD, 16'd1));
    directed_rows.push_back(row_write(CFG_HALF_PERIOD, 16'd0));
    directed_rows.push_back(row_checked(mk_tick(0, 1, 8'hFF, 1),
                                        res(1, 0, 1, 0, 0, 8'h00, 0, 8'h00, 5'd0)));
    for (int k = 0; k < 9; k++)
      directed_rows.push_back(row_tick(mk_tick(a5_frame[k], k == 3, 8'h3C, k == 5)));
    directed_rows.push_back(row_checked(mk_tick(1, 0, 8'h00, 0),
                                        res(1, 0, 0, 1, 0, 8'hA5, 0, 8'h00, 5'd1)));
    directed_rows.push_back(row_checked(mk_tick(1, 0, 8'h00, 1),
                                        res(1, 0, 0, 0, 0, 8'hA5, 1, 8'hA5, 5'd0)));
    directed_rows.push_back(row_checked(mk_tick(1, 1, 8'h00, 0),
                                        res(1, 1, 0, 0, 0, 8'hA5, 0, 8'h00, 5'd0)));
    directed_rows.push_back(row_tick(mk_tick(0, 1, 8'hFF, 1)));
    directed_rows.push_back(row_tick(mk_tick(1, 1, 8'h5A, 0)));
    directed_rows.push_back(row_tick(mk_tick(1, 0, 8'h00, 1)));
    directed_rows.push_back(row_tick(mk_tick(1, 0, 8'h00, 0)));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_write)
        write_reg(directed_rows[i].reg_sel, directed_rows[i].reg_val);
      else
        drive_tick(directed_rows[i].tick, directed_rows[i].typed, directed_rows[i].want);
    end

    // no pops at first so the stack fills and later bytes are dropped
    run_phase(16'd1, 16'd0, 400, 0, 5, 5, 1'b0);
    run_phase(16'd4, 16'd2, 300, 25, 10, 20, 1'b1);
    run_phase(16'd3, 16'd1, 300, 8, 35, 15, 1'b0);
    // sample point lands past the bit cell
    run_phase(16'd2, 16'd5, 150, 10, 10, 20, 1'b0);

    // widest timing: line held idle, only pops
    write_reg(CFG_BIT_PERIOD, 16'hFFFF);
    write_reg(CFG_HALF_PERIOD, 16'h7FFF);
    repeat (40) rand_tick(1'b1, 50, 0);

    run_phase(16'd1, 16'd3, 150, 10, 15, 15, 1'b0);

    in_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d ticks over %0d register writes: %0d frames received, %0d framing errors,",
             ticks_sent, n_cfg_writes, n_good, n_bad);
    $display("%0d bytes dropped on a full stack, %0d pops, %0d transmits, %0d results checked.",
             n_drops, n_pops, n_sends, results_checked);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: sim.f
sv/hdu_pkg.sv
sv/hdu_ram.sv
sv/half_duplex_uart_with_rx_stack.sv
tb/tb.sv
